@@ sv/rpl_pkg.sv @@
// Shared types and codes for the paged-memory replacement block.
// Holds the command/result payload structs and the default parameter values.
// No dependencies.
package rpl_pkg;

    // Default sizing
    localparam int MAX_PROCESSES_DEF = 16;
    localparam int TABLE_PAGES_DEF   = 1024;
    localparam int STAMP_WIDTH_DEF   = 32;

    // Fixed field widths
    localparam int LOC_W = 20;
    localparam int PSZ_W = 10;
    localparam int CFG_W = 11;

    // Operation codes
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_ACCESS = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_HIT   = 3'd0;
    localparam logic [2:0] ST_FAULT = 3'd1;
    localparam logic [2:0] ST_ADDED = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;

    // Replacement policies (code three acts as LRU)
    localparam logic [1:0] POL_CLOCK = 2'd0;
    localparam logic [1:0] POL_FIFO  = 2'd1;
    localparam logic [1:0] POL_LRU   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_POLICY    = 2'd0;
    localparam logic [1:0] REG_PREPAGING = 2'd1;
    localparam logic [1:0] REG_PAGE_SIZE = 2'd2;
    localparam logic [1:0] REG_INIT_RES  = 2'd3;

    typedef struct packed {
        logic        op;
        logic [3:0]  process_id;
        logic [10:0] page_count;
        logic [19:0] location;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  page;
        logic [3:0]  new_process;
        logic [9:0]  victim;
        logic        prefetch_done;
        logic [9:0]  prefetch_page;
        logic [9:0]  prefetch_victim;
        logic [31:0] fault_count;
        logic        stamp_overflow;
    } t_res;

endpackage

@@ sv/rpl_div.sv @@
// Restoring divider, one quotient bit per cycle: location offset by page size.
// Depends on rpl_pkg for field widths.
module rpl_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [rpl_pkg::LOC_W-1:0] i_dividend,
    input  logic [rpl_pkg::PSZ_W-1:0] i_divisor,
    output logic                    o_done,
    output logic [rpl_pkg::LOC_W-1:0] o_quot
);
    localparam int QW = rpl_pkg::LOC_W;
    localparam int DW = rpl_pkg::PSZ_W;
    localparam int KW = $clog2(QW + 1);

    logic          r_busy;
    logic          r_done;
    logic [KW-1:0] r_k;
    logic [QW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_div;
    logic [DW:0]   n_sh;

    // shifted partial remainder
    assign n_sh = {r_rem[DW-1:0], r_q[QW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                if (n_sh >= {1'b0, r_div}) begin
                    r_rem <= n_sh - {1'b0, r_div};
                    r_q   <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_rem <= n_sh;
                    r_q   <= {r_q[QW-2:0], 1'b0};
                end
                r_k <= r_k + 1'b1;
                if (r_k == KW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ sv/rpl_page_mem.sv @@
// Page table memory: one write port, one read port, registered read data.
// No dependencies.
module rpl_page_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 34
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/page_replacement_clock_fifo_lru.sv @@
// An add that fits writes each page-table entry of its region in turn, then strobes its
// result. An access first runs the location divider; a fault then scans the region's
// page-table entries for a victim (up to 2n visits for CLOCK, n for FIFO/LRU), and with
// prepaging searches the region for an invalid page and, if one is found, scans again.
// One item at a time: busy stays high through the result strobe cycle, so the next
// item is accepted in the cycle after the strobe at the earliest.
// Synchronous active-low reset; the page table needs no clearing pass since an add
// writes every entry of its region. The receiver cannot stall results.
module page_replacement_clock_fifo_lru #(
    parameter int MAX_PROCESSES = rpl_pkg::MAX_PROCESSES_DEF,
    parameter int TABLE_PAGES   = rpl_pkg::TABLE_PAGES_DEF,
    parameter int STAMP_WIDTH   = rpl_pkg::STAMP_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  rpl_pkg::t_cmd             i_cmd,
    output logic                      o_done,
    output rpl_pkg::t_res             o_res,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [rpl_pkg::CFG_W-1:0] i_cfg_data
);
    localparam int PW   = $clog2(TABLE_PAGES);
    localparam int CW   = PW + 1;
    localparam int PIDW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int PTW  = $clog2(MAX_PROCESSES + 1);
    localparam int XW   = (PTW > 4) ? PTW : 4;
    localparam int SUMW = ((CW > 11) ? CW : 11) + 1;
    localparam int MW   = STAMP_WIDTH + 2;
    localparam int VB   = MW - 1;
    localparam int RB   = MW - 2;
    localparam logic [STAMP_WIDTH-1:0] STAMP_MAX = {STAMP_WIDTH{1'b1}};

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ACHK = 4'd1;
    localparam logic [3:0] S_ADD  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_GRD  = 4'd5;
    localparam logic [3:0] S_GEV  = 4'd6;
    localparam logic [3:0] S_VST  = 4'd7;
    localparam logic [3:0] S_VRD  = 4'd8;
    localparam logic [3:0] S_VEV  = 4'd9;
    localparam logic [3:0] S_NONE = 4'd10;
    localparam logic [3:0] S_BW1  = 4'd11;
    localparam logic [3:0] S_BW2  = 4'd12;
    localparam logic [3:0] S_PST  = 4'd13;
    localparam logic [3:0] S_PRD  = 4'd14;
    localparam logic [3:0] S_PEV  = 4'd15;
    // Result strobe state shares the idle decode through r_out
    logic [3:0] r_state;
    logic       r_out;

    // Configuration
    logic [1:0]                r_policy;
    logic                      r_prepaging;
    logic [rpl_pkg::PSZ_W-1:0] r_page_size;
    logic [10:0]               r_init_res;

    // Region tables and global counters
    logic [CW-1:0]          r_base [MAX_PROCESSES];
    logic [CW-1:0]          r_end  [MAX_PROCESSES];
    logic [PW-1:0]          r_hand [MAX_PROCESSES];
    logic [PTW-1:0]         r_ptotal;
    logic [CW-1:0]          r_nfp;
    logic [STAMP_WIDTH-1:0] r_stamp;
    logic [31:0]            r_fault;

    // Per-item working registers
    rpl_pkg::t_cmd          r_in;
    logic [PIDW-1:0]        r_pid;
    logic [CW-1:0]          r_b, r_e, r_n;
    logic [PW-1:0]          r_addr, r_rel, r_g, r_vic, r_nxt;
    logic [CW-1:0]          r_k, r_cnt, r_resn;
    logic                   r_seen, r_found, r_phase;
    logic [STAMP_WIDTH-1:0] r_min;
    logic [MW-1:0]          r_gword, r_vword, r_nword;

    // Result registers
    logic [2:0]  r_status;
    logic [CW-1:0] r_page;
    logic [3:0]  r_newp;
    logic [PW-1:0] r_victim, r_ppage, r_pvic;
    logic        r_pdone;

    // Memory and divider hookup
    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata;
    logic [MW-1:0] rd;
    logic          div_start, div_done;
    logic [rpl_pkg::LOC_W-1:0] div_q;
    logic [rpl_pkg::PSZ_W-1:0] psz;

    logic                   accept;
    logic                   pol_clock, pol_fifo;
    logic                   take;
    logic [STAMP_WIDTH-1:0] n_stamp;
    logic [PIDW-1:0]        pidx, tidx;
    logic [SUMW-1:0]        add_sum;
    logic [10:0]            add_res;
    logic                   rng_err;
    logic [PW-1:0]          nrel, nwrap;
    logic [MW-1:0]          add_word;

    assign accept    = start && !busy;
    assign pol_clock = (r_policy == rpl_pkg::POL_CLOCK);
    assign pol_fifo  = (r_policy == rpl_pkg::POL_FIFO);
    assign n_stamp   = (r_stamp == STAMP_MAX) ? r_stamp : r_stamp + 1'b1;
    assign psz       = (r_page_size == '0) ? rpl_pkg::PSZ_W'(1) : r_page_size;
    assign div_start = accept && (i_cmd.op == rpl_pkg::OP_ACCESS);
    assign pidx      = PIDW'(r_in.process_id);
    assign tidx      = PIDW'(r_ptotal);
    assign add_sum   = SUMW'(r_nfp) + SUMW'(r_in.page_count);
    assign add_res   = (r_in.page_count < r_init_res) ? r_in.page_count : r_init_res;

    // Range check of an access against its region
    assign rng_err = (XW'(r_in.process_id) >= XW'(r_ptotal)) || (r_in.location == '0)
                  || (div_q >= rpl_pkg::LOC_W'(r_end[pidx] - r_base[pidx]));

    // Next relative scan position (clock) and next wrapped address (prepage)
    assign nrel  = (CW'(r_rel) + 1'b1 == r_n) ? '0 : r_rel + 1'b1;
    assign nwrap = (CW'(r_addr) + 1'b1 == r_e) ? PW'(r_b) : r_addr + 1'b1;

    // Entry written by an add sweep
    always_comb begin
        add_word     = '0;
        add_word[VB] = (r_cnt < r_resn);
        add_word[RB] = (r_cnt < r_resn) && pol_clock;
        if ((r_cnt < r_resn) && pol_fifo) begin
            add_word[STAMP_WIDTH-1:0] = r_stamp;
        end
    end

    rpl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_cmd.location - 1'b1),
        .i_divisor  (psz),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    rpl_page_mem #(
        .DEPTH (TABLE_PAGES),
        .AW    (PW),
        .DW    (MW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (rd)
    );

    // Memory write port and stamp consumption per state
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = rd;
        take      = 1'b0;
        case (r_state)
            S_ADD: begin
                mem_we    = 1'b1;
                mem_wdata = add_word;
                take      = (r_cnt < r_resn) && pol_fifo;
            end
            S_GEV: begin
                if (rd[VB] && pol_clock) begin
                    mem_we        = 1'b1;
                    mem_wdata[RB] = 1'b1;
                end else if (rd[VB] && !pol_fifo) begin
                    mem_we                     = 1'b1;
                    mem_wdata[STAMP_WIDTH-1:0] = r_stamp;
                    take                       = 1'b1;
                end
            end
            S_VEV: begin
                if (pol_clock && rd[VB] && rd[RB]) begin
                    mem_we        = 1'b1;
                    mem_wdata[RB] = 1'b0;
                end
            end
            S_BW1: begin
                mem_we        = 1'b1;
                mem_waddr     = r_vic;
                mem_wdata     = r_vword;
                mem_wdata[VB] = 1'b0;
            end
            S_BW2: begin
                mem_we        = 1'b1;
                mem_waddr     = r_phase ? r_nxt : r_g;
                mem_wdata     = r_phase ? r_nword : r_gword;
                mem_wdata[VB] = 1'b1;
                if (pol_clock) begin
                    mem_wdata[RB] = 1'b1;
                end else begin
                    mem_wdata[STAMP_WIDTH-1:0] = r_stamp;
                    take                       = 1'b1;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= rpl_pkg::POL_CLOCK;
            r_prepaging <= 1'b0;
            r_page_size <= rpl_pkg::PSZ_W'(1);
            r_init_res  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rpl_pkg::REG_POLICY:    r_policy    <= i_cfg_data[1:0];
                rpl_pkg::REG_PREPAGING: r_prepaging <= i_cfg_data[0];
                rpl_pkg::REG_PAGE_SIZE: r_page_size <= i_cfg_data[rpl_pkg::PSZ_W-1:0];
                rpl_pkg::REG_INIT_RES:  r_init_res  <= i_cfg_data[10:0];
                default:                r_policy    <= r_policy;
            endcase
        end
    end

    // Stamp counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp <= STAMP_WIDTH'(1);
        end else if (take) begin
            r_stamp <= n_stamp;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_out    <= 1'b0;
            r_ptotal <= '0;
            r_nfp    <= '0;
            r_fault  <= '0;
        end else begin
            r_out <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_in     <= i_cmd;
                        r_status <= rpl_pkg::ST_HIT;
                        r_page   <= '0;
                        r_newp   <= '0;
                        r_victim <= '0;
                        r_pdone  <= 1'b0;
                        r_ppage  <= '0;
                        r_pvic   <= '0;
                        r_phase  <= 1'b0;
                        r_state  <= (i_cmd.op == rpl_pkg::OP_ADD) ? S_ACHK : S_DIV;
                    end
                end
                S_ACHK: begin
                    if (r_ptotal >= PTW'(MAX_PROCESSES) || add_sum > SUMW'(TABLE_PAGES)) begin
                        r_status <= rpl_pkg::ST_FULL;
                        r_out    <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_base[tidx] <= r_nfp;
                        r_end[tidx]  <= CW'(add_sum);
                        r_hand[tidx] <= '0;
                        r_ptotal     <= r_ptotal + 1'b1;
                        r_nfp        <= CW'(add_sum);
                        r_status     <= rpl_pkg::ST_ADDED;
                        r_page       <= r_nfp;
                        r_newp       <= 4'(r_ptotal);
                        r_addr       <= PW'(r_nfp);
                        r_cnt        <= '0;
                        r_resn       <= CW'(add_res);
                        if (r_in.page_count == '0) begin
                            r_out   <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ADD;
                        end
                    end
                end
                S_ADD: begin
                    r_cnt  <= r_cnt + 1'b1;
                    r_addr <= r_addr + 1'b1;
                    if (r_cnt + 1'b1 == CW'(r_in.page_count)) begin
                        r_out   <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (rng_err) begin
                        r_status <= rpl_pkg::ST_RANGE;
                        r_out    <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_pid   <= pidx;
                        r_b     <= r_base[pidx];
                        r_e     <= r_end[pidx];
                        r_n     <= r_end[pidx] - r_base[pidx];
                        r_g     <= PW'(r_base[pidx] + CW'(div_q));
                        r_addr  <= PW'(r_base[pidx] + CW'(div_q));
                        r_page  <= r_base[pidx] + CW'(div_q);
                        r_state <= S_GRD;
                    end
                end
                S_GRD: r_state <= S_GEV;
                S_GEV: begin
                    r_gword <= rd;
                    if (rd[VB]) begin
                        r_out   <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_VST;
                    end
                end
                // Victim scan setup
                S_VST: begin
                    r_k     <= '0;
                    r_seen  <= 1'b0;
                    r_found <= 1'b0;
                    if (pol_clock) begin
                        r_rel  <= r_hand[r_pid];
                        r_addr <= PW'(r_b + CW'(r_hand[r_pid]));
                    end else begin
                        r_addr <= PW'(r_b);
                    end
                    r_state <= S_VRD;
                end
                S_VRD: r_state <= S_VEV;
                S_VEV: begin
                    if (pol_clock) begin
                        if (rd[VB] && !rd[RB]) begin
                            r_vic         <= r_addr;
                            r_vword       <= rd;
                            r_hand[r_pid] <= nrel;
                            r_state       <= S_BW1;
                        end else if (r_k + 1'b1 == r_n && !(r_seen || rd[VB])) begin
                            r_state <= S_NONE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_seen  <= r_seen || rd[VB];
                            r_rel   <= nrel;
                            r_addr  <= PW'(r_b + CW'(nrel));
                            r_state <= S_VRD;
                        end
                    end else begin
                        if (rd[VB] && (!r_found || rd[STAMP_WIDTH-1:0] <= r_min)) begin
                            r_found <= 1'b1;
                            r_min   <= rd[STAMP_WIDTH-1:0];
                            r_vic   <= r_addr;
                            r_vword <= rd;
                        end
                        if (CW'(r_addr) + 1'b1 == r_e) begin
                            r_state <= (r_found || rd[VB]) ? S_BW1 : S_NONE;
                        end else begin
                            r_addr  <= r_addr + 1'b1;
                            r_state <= S_VRD;
                        end
                    end
                end
                S_NONE: begin
                    if (!r_phase) begin
                        r_status <= rpl_pkg::ST_FULL;
                    end
                    r_out   <= 1'b1;
                    r_state <= S_IDLE;
                end
                // Bring-in: retire the victim, then load the page
                S_BW1: begin
                    if (!r_phase) begin
                        r_status <= rpl_pkg::ST_FAULT;
                        r_victim <= r_vic;
                        if (r_fault != 32'hFFFF_FFFF) begin
                            r_fault <= r_fault + 1'b1;
                        end
                    end
                    r_state <= S_BW2;
                end
                S_BW2: begin
                    if (r_phase) begin
                        r_pdone <= 1'b1;
                        r_ppage <= r_nxt;
                        r_pvic  <= r_vic;
                        r_out   <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_prepaging && r_n != CW'(1)) begin
                        r_state <= S_PST;
                    end else begin
                        r_out   <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                // Prepage search for the next invalid page, wrapping in the region
                S_PST: begin
                    r_addr  <= (CW'(r_g) + 1'b1 == r_e) ? PW'(r_b) : r_g + 1'b1;
                    r_k     <= '0;
                    r_state <= S_PRD;
                end
                S_PRD: r_state <= S_PEV;
                S_PEV: begin
                    if (!rd[VB]) begin
                        r_nxt   <= r_addr;
                        r_nword <= rd;
                        r_phase <= 1'b1;
                        r_state <= S_VST;
                    end else if (r_k + CW'(2) == r_n) begin
                        r_out   <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_addr  <= nwrap;
                        r_state <= S_PRD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Outputs
    assign busy   = (r_state != S_IDLE) || r_out;
    assign o_done = r_out;

    always_comb begin
        o_res                 = '0;
        o_res.status          = r_status;
        o_res.page            = 10'(r_page);
        o_res.new_process     = r_newp;
        o_res.victim          = 10'(r_victim);
        o_res.prefetch_done   = r_pdone;
        o_res.prefetch_page   = 10'(r_ppage);
        o_res.prefetch_victim = 10'(r_pvic);
        o_res.fault_count     = r_fault;
        o_res.stamp_overflow  = (r_stamp == STAMP_MAX);
    end

    // Checks
    a_done_only_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) != S_IDLE)
        else $error("result strobe without an item in flight");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("page table written while idle");

    a_fault_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> r_fault >= $past(r_fault))
        else $error("fault counter went backwards");

    a_stamp_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> r_stamp >= $past(r_stamp))
        else $error("stamp counter went backwards");

    a_bring_in_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BW1) |=> (r_state == S_BW2))
        else $error("victim retired without loading the page");

endmodule

@@ test/page_replacement_clock_fifo_lru_tb.sv @@
// Testbench for page_replacement_clock_fifo_lru: directed and random add/access
// commands checked against an in-bench page-table predictor as whole result structs.
// Depends on rpl_pkg and the block under test.
`timescale 1ns / 100ps

module page_replacement_clock_fifo_lru_tb;

    localparam int NPROC    = 16;
    localparam int NPAGES   = 1024;
    localparam int WATCHDOG = 20000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    rpl_pkg::t_cmd i_cmd = '0;
    logic          o_done;
    rpl_pkg::t_res o_res;
    logic          i_cfg_we = 1'b0;
    logic [1:0]    i_cfg_idx = '0;
    logic [10:0]   i_cfg_data = '0;

    page_replacement_clock_fifo_lru i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .o_done(o_done), .o_res(o_res),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state: a copy of the page table and region bookkeeping
    logic        pt_valid [NPAGES];
    logic        pt_ref   [NPAGES];
    logic [31:0] pt_stamp [NPAGES];
    int unsigned rg_base [NPROC];
    int unsigned rg_end  [NPROC];
    int unsigned rg_hand [NPROC];
    int unsigned n_procs, free_page, n_faults;
    logic [31:0] stamp_ctr;
    logic [1:0]  cfg_policy;
    logic        cfg_prepage;
    logic [9:0]  cfg_psize;
    logic [10:0] cfg_resident;

    rpl_pkg::t_cmd pending_cmds[$];
    rpl_pkg::t_res expected_res[$];
    int   n_sent, n_results, n_mismatch, idle_cnt;
    bit   quiet_run;

    function automatic logic [31:0] next_stamp();
        logic [31:0] s;
        s = stamp_ctr;
        if (stamp_ctr != 32'hFFFF_FFFF) stamp_ctr++;
        return s;
    endfunction

    // Returns victim page or -1 when the region holds no resident page
    function automatic int pick_victim(int unsigned p);
        int unsigned b, e, n, off, j;
        int pick;
        b = rg_base[p]; e = rg_end[p]; n = e - b; pick = -1;
        for (int unsigned i = b; i < e; i++)
            if (pt_valid[i]) begin pick = i; break; end
        if (pick < 0) return -1;
        if (cfg_policy == rpl_pkg::POL_CLOCK) begin
            off = rg_hand[p] % n;
            for (int unsigned k = 0; k < 2 * n + 1; k++) begin
                j = b + (off + k) % n;
                if (!pt_valid[j]) continue;
                if (pt_ref[j]) pt_ref[j] = 1'b0;
                else begin
                    rg_hand[p] = (j - b + 1) % n;
                    return j;
                end
            end
            return pick;
        end
        for (int unsigned i = b; i < e; i++)
            if (pt_valid[i] && pt_stamp[i] <= pt_stamp[pick]) pick = i;
        return pick;
    endfunction

    function automatic void bring_page_in(int unsigned pg, int unsigned vic);
        pt_valid[vic] = 1'b0;
        pt_valid[pg]  = 1'b1;
        if (cfg_policy == rpl_pkg::POL_CLOCK) pt_ref[pg] = 1'b1;
        else pt_stamp[pg] = next_stamp();
    endfunction

    function automatic rpl_pkg::t_res predict_result(rpl_pkg::t_cmd c);
        rpl_pkg::t_res r;
        int unsigned b, e, g, res, psz, off;
        int v, v2, nxt;
        r = '0;
        if (cfg_policy == 2'd3) cfg_policy = rpl_pkg::POL_LRU;
        if (c.op == rpl_pkg::OP_ADD) begin
            if (n_procs >= NPROC || free_page + c.page_count > NPAGES) begin
                r.status = rpl_pkg::ST_FULL;
            end else begin
                b = free_page;
                res = (c.page_count < cfg_resident) ? c.page_count : cfg_resident;
                rg_base[n_procs] = b;
                rg_end[n_procs]  = b + c.page_count;
                rg_hand[n_procs] = 0;
                for (int unsigned i = b; i < b + res; i++) begin
                    pt_valid[i] = 1'b1;
                    if (cfg_policy == rpl_pkg::POL_CLOCK) pt_ref[i] = 1'b1;
                    else if (cfg_policy == rpl_pkg::POL_FIFO) pt_stamp[i] = next_stamp();
                    else pt_stamp[i] = '0;
                end
                r.status = rpl_pkg::ST_ADDED;
                r.page = 10'(b);
                r.new_process = 4'(n_procs);
                n_procs++;
                free_page = b + c.page_count;
            end
        end else begin
            psz = (cfg_psize == 0) ? 1 : cfg_psize;
            off = (c.location - 1) / psz;
            if (c.process_id >= n_procs || c.location == 0 ||
                off >= rg_end[c.process_id] - rg_base[c.process_id]) begin
                r.status = rpl_pkg::ST_RANGE;
            end else begin
                b = rg_base[c.process_id]; e = rg_end[c.process_id];
                g = b + off;
                r.page = 10'(g);
                if (pt_valid[g]) begin
                    r.status = rpl_pkg::ST_HIT;
                    if (cfg_policy == rpl_pkg::POL_CLOCK) pt_ref[g] = 1'b1;
                    else if (cfg_policy == rpl_pkg::POL_LRU) pt_stamp[g] = next_stamp();
                end else begin
                    v = pick_victim(c.process_id);
                    if (v < 0) r.status = rpl_pkg::ST_FULL;
                    else begin
                        r.status = rpl_pkg::ST_FAULT;
                        if (n_faults != 32'hFFFF_FFFF) n_faults++;
                        bring_page_in(g, v);
                        r.victim = 10'(v);
                        if (cfg_prepage) begin
                            nxt = -1;
                            for (int unsigned i = g + 1; i < e && nxt < 0; i++)
                                if (!pt_valid[i]) nxt = i;
                            for (int unsigned i = b; i < g && nxt < 0; i++)
                                if (!pt_valid[i]) nxt = i;
                            if (nxt >= 0) begin
                                v2 = pick_victim(c.process_id);
                                if (v2 >= 0) begin
                                    bring_page_in(nxt, v2);
                                    r.prefetch_done = 1'b1;
                                    r.prefetch_page = 10'(nxt);
                                    r.prefetch_victim = 10'(v2);
                                end
                            end
                        end
                    end
                end
            end
        end
        r.fault_count = n_faults;
        r.stamp_overflow = (stamp_ctr == 32'hFFFF_FFFF);
        return r;
    endfunction

    // Driver: issues queued commands; random idle gaps outside the quiet run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            expected_res.push_back(predict_result(i_cmd));
            n_sent++;
            if (pending_cmds.size() != 0 && (quiet_run || $urandom_range(99) >= 7)) begin
                i_cmd <= pending_cmds.pop_front();
            end else begin
                start <= 1'b0;
            end
        end else if (!start && pending_cmds.size() != 0 &&
                     (quiet_run || $urandom_range(99) >= 7)) begin
            i_cmd <= pending_cmds.pop_front();
            start <= 1'b1;
        end
    end

    // Monitor: compares each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        rpl_pkg::t_res exp_r;
        if (i_rst_n && o_done) begin
            n_results++;
            if (expected_res.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %p", o_res);
            end else begin
                exp_r = expected_res.pop_front();
                if (o_res !== exp_r) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch #%0d: expected %p got %p",
                                 n_results, exp_r, o_res);
                end
            end
        end
    end

    // Watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG) begin
            $display("page_replacement_clock_fifo_lru_tb: errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            rpl_pkg::REG_POLICY:    cfg_policy   = val[1:0];
            rpl_pkg::REG_PREPAGING: cfg_prepage  = val[0];
            rpl_pkg::REG_PAGE_SIZE: cfg_psize    = val[9:0];
            default:                cfg_resident = val;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || start || busy || expected_res.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic rpl_pkg::t_cmd mk_cmd(logic op, logic [3:0] pid, logic [10:0] cnt,
                                             logic [19:0] loc);
        rpl_pkg::t_cmd c;
        c.op = op; c.process_id = pid; c.page_count = cnt; c.location = loc;
        return c;
    endfunction

    initial begin
        foreach (pt_valid[i]) begin
            pt_valid[i] = 0; pt_ref[i] = 0; pt_stamp[i] = 0;
        end
        foreach (rg_base[i]) begin
            rg_base[i] = 0; rg_end[i] = 0; rg_hand[i] = 0;
        end
        n_procs = 0; free_page = 0; n_faults = 0; stamp_ctr = 1;
        cfg_policy = rpl_pkg::POL_CLOCK; cfg_prepage = 0; cfg_psize = 1; cfg_resident = 0;
        n_sent = 0; n_results = 0; n_mismatch = 0; idle_cnt = 0;
        quiet_run = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: clock policy, page size of zero, accesses with no victim
        write_reg(rpl_pkg::REG_POLICY, 11'(rpl_pkg::POL_CLOCK));
        write_reg(rpl_pkg::REG_PREPAGING, 11'd1);
        write_reg(rpl_pkg::REG_PAGE_SIZE, 11'd0);
        write_reg(rpl_pkg::REG_INIT_RES, 11'd2);
        pending_cmds.push_back(mk_cmd(rpl_pkg::OP_ACCESS, 4'd0, 11'd0, 20'd1));  // no process
        pending_cmds.push_back(mk_cmd(rpl_pkg::OP_ADD, 4'hF, 11'd4, 20'hFFFFF));
        pending_cmds.push_back(mk_cmd(rpl_pkg::OP_ACCESS, 4'd0, 11'h7FF, 20'd0)); // location 0
        pending_cmds.push_back(mk_cmd(rpl_pkg::OP_ACCESS, 4'd0, 11'd0, 20'd1));
        pending_cmds.push_back(mk_cmd(rpl_pkg::OP_ACCESS, 4'd0, 11'd0, 20'd3));  // prepage
        pending_cmds.push_back(mk_cmd(rpl_pkg::OP_ACCESS, 4'd0, 11'd0, 20'd4));
        pending_cmds.push_back(mk_cmd(rpl_pkg::OP_ACCESS, 4'd0, 11'd0, 20'd5));  // beyond
        pending_cmds.push_back(mk_cmd(rpl_pkg::OP_ADD, 4'd0, 11'd0, 20'd0));     // empty region
        pending_cmds.push_back(mk_cmd(rpl_pkg::OP_ADD, 4'd0, 11'd2000, 20'd0));  // overflow
        pending_cmds.push_back(mk_cmd(rpl_pkg::OP_ACCESS, 4'd1, 11'd0, 20'd1));
        wait_drained();
        write_reg(rpl_pkg::REG_INIT_RES, 11'd0);
        pending_cmds.push_back(mk_cmd(rpl_pkg::OP_ADD, 4'd0, 11'd3, 20'd0));     // none resident
        pending_cmds.push_back(mk_cmd(rpl_pkg::OP_ACCESS, 4'd2, 11'd0, 20'd2));  // no victim
        wait_drained();
        // Page size of 512 and the largest location
        write_reg(rpl_pkg::REG_PAGE_SIZE, 11'd512);
        write_reg(rpl_pkg::REG_INIT_RES, 11'd1024);
        write_reg(rpl_pkg::REG_POLICY, 11'(rpl_pkg::POL_FIFO));
        pending_cmds.push_back(mk_cmd(rpl_pkg::OP_ADD, 4'd0, 11'd1017, 20'd0));  // fills table
        pending_cmds.push_back(mk_cmd(rpl_pkg::OP_ACCESS, 4'd3, 11'd0, 20'hFFFFF));
        pending_cmds.push_back(mk_cmd(rpl_pkg::OP_ACCESS, 4'd3, 11'd0, 20'd512));
        pending_cmds.push_back(mk_cmd(rpl_pkg::OP_ADD, 4'd0, 11'd1, 20'd0));     // table full
        wait_drained();

        // Random phases over a fresh tail of the table is impossible (full), so
        // random traffic runs on the regions already present plus errors.
        write_reg(rpl_pkg::REG_PAGE_SIZE, 11'd1);
        write_reg(rpl_pkg::REG_INIT_RES, 11'd2);
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(rpl_pkg::REG_POLICY, 11'(ph[1:0]));
            write_reg(rpl_pkg::REG_PREPAGING, {10'd0, ph[0]});
            quiet_run = (ph == 2);
            for (int i = 0; i < 31; i++) begin
                if ($urandom_range(9) == 0)
                    pending_cmds.push_back(mk_cmd(1'($urandom), 4'($urandom),
                                                  11'($urandom), 20'($urandom)));
                else
                    pending_cmds.push_back(mk_cmd(rpl_pkg::OP_ACCESS,
                                                  4'($urandom_range(3)), 11'($urandom),
                                                  20'($urandom_range(1, 6))));
            end
            wait_drained();
        end
        quiet_run = 0;

        $display("run covered %0d commands over all policies, prepaging on and off,",
                 n_sent);
        $display("page sizes 0/1/512 and region, range and table-full cases");
        if (n_mismatch == 0 && expected_res.size() == 0)
            $display("page_replacement_clock_fifo_lru_tb: clean");
        else
            $display("page_replacement_clock_fifo_lru_tb: errors");
        $finish;
    end
endmodule

@@ page_replacement_clock_fifo_lru.f @@
sv/rpl_pkg.sv
sv/rpl_div.sv
sv/rpl_page_mem.sv
sv/page_replacement_clock_fifo_lru.sv
test/page_replacement_clock_fifo_lru_tb.sv
